>>> rtl/plane_overlay_palette_manager_core_assert.svh
// Assertion macros shared by the RTL; every check is clocked on clk and
// held off while rst is high.
`ifndef PLANE_OVERLAY_PALETTE_MANAGER_CORE_ASSERT_SVH
`define PLANE_OVERLAY_PALETTE_MANAGER_CORE_ASSERT_SVH

// Same-cycle implication.
`define POPM_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication.
`define POPM_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

>>> rtl/popm_pkg.sv
package popm_pkg;

  localparam int NUM_PLANES_DEF = 4;
  localparam int PLANES_MAX     = 4;

  localparam int FUNC_W  = 2;
  localparam int PLANE_W = 3;
  localparam int CHAN_W  = 4;
  localparam int COLOR_W = 12;
  localparam int SLOT_W  = 4;

  localparam int S_TDATA_W = 16;
  localparam int S_TUSER_W = FUNC_W;
  localparam int M_TDATA_W = 16;
  localparam int M_TUSER_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_SET    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SHOW   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_HIDE   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_WALK,
    ST_BAD
  } popm_state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic emit;
    logic emit_bad;
  } dp_cmd_t;

  typedef struct packed {
    logic in_ignore;
    logic in_bad;
    logic pend_empty;
    logic out_free;
  } dp_stat_t;

endpackage

>>> rtl/popm_ctrl.sv
module popm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  popm_pkg::dp_stat_t stat,
  output popm_pkg::dp_cmd_t  cmd,
  output popm_pkg::popm_state_t state
);
  import popm_pkg::*;

  popm_state_t state_next;
  logic        accept;

  assign accept = s_tvalid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && !stat.in_ignore) begin
          state_next = stat.in_bad ? ST_BAD : ST_PREP;
        end
      end
      ST_PREP: state_next = ST_WALK;
      ST_WALK: begin
        if (stat.pend_empty) begin
          state_next = ST_IDLE;
        end
      end
      ST_BAD: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = accept && !stat.in_ignore && !stat.in_bad;
      end
      ST_PREP: cmd.prep = 1'b1;
      ST_WALK: cmd.emit = !stat.pend_empty && stat.out_free;
      ST_BAD:  cmd.emit_bad = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

>>> rtl/popm_dp.sv
module popm_dp #(
  parameter int NUM_PLANES = popm_pkg::NUM_PLANES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  popm_pkg::dp_cmd_t               cmd,
  output popm_pkg::dp_stat_t              stat,
  input  logic [popm_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic [popm_pkg::S_TUSER_W-1:0]  s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [popm_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic [popm_pkg::M_TUSER_W-1:0]  m_tuser,
  output logic                            m_tlast
);
  import popm_pkg::*;

  localparam int PLANE_SLOTS = 1 << NUM_PLANES;
  localparam int SLOT_IW     = NUM_PLANES;
  localparam int PIDX_W      = $clog2(NUM_PLANES + 1);

  function automatic logic [PLANE_W-1:0] top_plane(input logic [PLANES_MAX-1:0] bits);
    logic [PLANE_W-1:0] r;
    r = '0;
    for (int p = 0; p < PLANES_MAX; p++) begin
      if (bits[p]) r = PLANE_W'(p + 1);
    end
    return r;
  endfunction

  // Input item unpacking
  logic [FUNC_W-1:0]  in_func;
  logic [PLANE_W-1:0] in_plane;
  logic [COLOR_W-1:0] in_color;
  logic [NUM_PLANES-1:0] in_bit;

  assign in_func  = s_tuser;
  assign in_plane = s_tdata[2:0];
  assign in_color = {s_tdata[14:11], s_tdata[10:7], s_tdata[6:3]};
  assign in_bit   = NUM_PLANES'(1) << (in_plane - PLANE_W'(1));

  // State
  logic [COLOR_W-1:0]    plane_color [NUM_PLANES+1];
  logic [PLANE_W-1:0]    slot_owner  [PLANE_SLOTS];
  logic [NUM_PLANES-1:0] shown_planes;
  logic [FUNC_W-1:0]     item_func;
  logic [PLANE_W-1:0]    item_plane;
  logic [PLANE_SLOTS-1:0] pend;
  logic [PLANE_SLOTS-1:0] pend_next;

  // Walk selection
  logic [SLOT_IW-1:0]     sel;
  logic [PLANE_SLOTS-1:0] sel_rest;
  logic [PLANE_W-1:0]     sel_tgt;
  logic [COLOR_W-1:0]     sel_color;
  logic                   is_set;

  assign is_set = (item_func == FUNC_SET);

  assign stat.in_ignore  = (in_func == FUNC_UNUSED);
  assign stat.in_bad     = (in_plane == '0) || (in_plane > PLANE_W'(NUM_PLANES));
  assign stat.pend_empty = (pend == '0);
  assign stat.out_free   = !m_tvalid || m_tready;

  always_comb begin
    pend_next = '0;
    for (int i = 1; i < PLANE_SLOTS; i++) begin
      if (is_set) begin
        pend_next[i] = (top_plane(PLANES_MAX'(i)) == item_plane);
      end else begin
        pend_next[i] = slot_owner[i] !=
                       top_plane(PLANES_MAX'(i) & PLANES_MAX'(shown_planes));
      end
    end
  end

  // Lowest pending slot goes first
  always_comb begin
    sel = '0;
    for (int i = PLANE_SLOTS - 1; i >= 0; i--) begin
      if (pend[i]) sel = SLOT_IW'(i);
    end
    sel_rest  = pend & ~(PLANE_SLOTS'(1) << sel);
    sel_tgt   = is_set ? item_plane
                       : top_plane(PLANES_MAX'(sel) & PLANES_MAX'(shown_planes));
    sel_color = plane_color[PIDX_W'(sel_tgt)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shown_planes <= '0;
      pend         <= '0;
      for (int p = 0; p <= NUM_PLANES; p++) plane_color[p] <= '0;
      for (int i = 0; i < PLANE_SLOTS; i++) slot_owner[i] <= '0;
    end else begin
      if (cmd.load) begin
        case (in_func)
          FUNC_SET: begin
            plane_color[PIDX_W'(in_plane)] <= in_color;
            shown_planes <= shown_planes | in_bit;
          end
          FUNC_SHOW: shown_planes <= shown_planes | in_bit;
          FUNC_HIDE: shown_planes <= shown_planes & ~in_bit;
          default:   shown_planes <= shown_planes;
        endcase
      end
      if (cmd.prep) begin
        pend <= pend_next;
      end else if (cmd.emit) begin
        pend            <= sel_rest;
        slot_owner[sel] <= sel_tgt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_func  <= in_func;
      item_plane <= in_plane;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit || cmd.emit_bad) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {sel_color, SLOT_W'(sel)};
      m_tuser <= 2'b01;
      m_tlast <= (sel_rest == '0);
    end else if (cmd.emit_bad) begin
      m_tdata <= '0;
      m_tuser <= 2'b10;
      m_tlast <= 1'b1;
    end
  end

endmodule

>>> rtl/plane_overlay_palette_manager_core.sv
// Plane overlay palette manager.
// Input channel (s_*): one command per transaction. tuser carries the
// command (set colour, show plane, hide plane); tdata carries the plane
// number and the red, green and blue intensities.
// Output channel (m_*): one palette write per transaction, tlast on the
// final write of a command. A plane outside the configured range yields a
// single flagged transaction with no write; an unused command code yields
// nothing.
// After a command is accepted, its pending slots are found by the scan and
// each write then passes through the output register, one write per cycle
// while the output is not stalled. A command occupies the block for the
// scan and for its slot walk through the owner table, one write per pending
// slot (at most 15), until no slot is pending and the controller goes idle.
// s_tready is high only while the controller is idle.
// Reset: all plane colours black, every slot owned by no plane, no plane
// shown, output channel empty.
// Stall: a held result stays in the output register; the slot walk pauses
// until the register frees, so no write is lost or repeated.
module plane_overlay_palette_manager_core #(
  parameter int NUM_PLANES = popm_pkg::NUM_PLANES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [2:0] plane, [6:3] red, [10:7] green, [14:11] blue, [15] zero
  input  logic [popm_pkg::S_TDATA_W-1:0]  s_tdata,
  // [1:0] func
  input  logic [popm_pkg::S_TUSER_W-1:0]  s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [3:0] vlt_slot, [15:4] color_word
  output logic [popm_pkg::M_TDATA_W-1:0]  m_tdata,
  // [0] write_valid, [1] bad_plane
  output logic [popm_pkg::M_TUSER_W-1:0]  m_tuser,
  output logic                            m_tlast
);
  import popm_pkg::*;

  `include "plane_overlay_palette_manager_core_assert.svh"

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  popm_state_t state;

  // Sequence the command: accept, scan, walk pending slots
  popm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd),
    .state    (state)
  );

  // Hold colours, owners, shown mask and the output register
  popm_dp #(
    .NUM_PLANES (NUM_PLANES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // A command that does work keeps the input closed in the next cycle
  `POPM_ASSERT_NEXT(a_busy_after_cmd,
                    s_tvalid && s_tready && s_tuser != FUNC_UNUSED,
                    !s_tready, "input open while command in progress")
  // A bad-plane result is a lone, non-write transaction
  `POPM_ASSERT_NOW(a_bad_alone, m_tvalid && m_tuser[1], m_tlast && !m_tuser[0],
                   "bad-plane result malformed")
  // Finished walk returns to idle
  `POPM_ASSERT_NEXT(a_walk_done, state == ST_WALK && stat.pend_empty, s_tready,
                    "walk did not return to idle")

endmodule
